>>> sv/aes_pkg.sv
// Package: shared types, S-box tables and round transform functions.
package aes_pkg;

	localparam int unsigned ROUND_KEY_COUNT = 11;
	localparam int unsigned RK_ADDR_W = 4;
	localparam int unsigned CFG_INDEX_W = 8;

	// register indexes on the configuration channel
	localparam logic [CFG_INDEX_W-1:0] REG_KEY_UPPER = 8'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_KEY_LOWER = 8'd1;

	// opcode values
	localparam logic OP_ENCRYPT = 1'b0;
	localparam logic OP_DECRYPT = 1'b1;

	localparam logic [7:0] RCON_FIRST = 8'h01;

	// command bundle from controller to datapath
	typedef struct packed {
		logic                 load;      // take block and key, start expansion
		logic                 expand;    // one key expansion step
		logic [RK_ADDR_W-1:0] waddr;     // round key store write address
		logic [RK_ADDR_W-1:0] raddr;     // round key store read address
		logic                 add_init;  // initial key addition
		logic                 round;     // one cipher round
		logic                 last;      // final round, no column mixing
		logic                 dec;       // inverse cipher
		logic                 capture;   // move result into output register
	} aes_cmd_t;

	localparam logic [7:0] SBOX [256] = '{
		8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
		8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
		8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
		8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
		8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
		8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
		8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
		8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
		8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
		8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
		8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
		8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
		8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
		8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
		8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
		8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
		8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
		8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
		8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
		8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
		8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
		8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
		8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
		8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
		8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
		8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
		8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
		8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
		8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
		8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
		8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
		8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
	};

	localparam logic [7:0] INV_SBOX [256] = '{
		8'h52, 8'h09, 8'h6a, 8'hd5, 8'h30, 8'h36, 8'ha5, 8'h38,
		8'hbf, 8'h40, 8'ha3, 8'h9e, 8'h81, 8'hf3, 8'hd7, 8'hfb,
		8'h7c, 8'he3, 8'h39, 8'h82, 8'h9b, 8'h2f, 8'hff, 8'h87,
		8'h34, 8'h8e, 8'h43, 8'h44, 8'hc4, 8'hde, 8'he9, 8'hcb,
		8'h54, 8'h7b, 8'h94, 8'h32, 8'ha6, 8'hc2, 8'h23, 8'h3d,
		8'hee, 8'h4c, 8'h95, 8'h0b, 8'h42, 8'hfa, 8'hc3, 8'h4e,
		8'h08, 8'h2e, 8'ha1, 8'h66, 8'h28, 8'hd9, 8'h24, 8'hb2,
		8'h76, 8'h5b, 8'ha2, 8'h49, 8'h6d, 8'h8b, 8'hd1, 8'h25,
		8'h72, 8'hf8, 8'hf6, 8'h64, 8'h86, 8'h68, 8'h98, 8'h16,
		8'hd4, 8'ha4, 8'h5c, 8'hcc, 8'h5d, 8'h65, 8'hb6, 8'h92,
		8'h6c, 8'h70, 8'h48, 8'h50, 8'hfd, 8'hed, 8'hb9, 8'hda,
		8'h5e, 8'h15, 8'h46, 8'h57, 8'ha7, 8'h8d, 8'h9d, 8'h84,
		8'h90, 8'hd8, 8'hab, 8'h00, 8'h8c, 8'hbc, 8'hd3, 8'h0a,
		8'hf7, 8'he4, 8'h58, 8'h05, 8'hb8, 8'hb3, 8'h45, 8'h06,
		8'hd0, 8'h2c, 8'h1e, 8'h8f, 8'hca, 8'h3f, 8'h0f, 8'h02,
		8'hc1, 8'haf, 8'hbd, 8'h03, 8'h01, 8'h13, 8'h8a, 8'h6b,
		8'h3a, 8'h91, 8'h11, 8'h41, 8'h4f, 8'h67, 8'hdc, 8'hea,
		8'h97, 8'hf2, 8'hcf, 8'hce, 8'hf0, 8'hb4, 8'he6, 8'h73,
		8'h96, 8'hac, 8'h74, 8'h22, 8'he7, 8'had, 8'h35, 8'h85,
		8'he2, 8'hf9, 8'h37, 8'he8, 8'h1c, 8'h75, 8'hdf, 8'h6e,
		8'h47, 8'hf1, 8'h1a, 8'h71, 8'h1d, 8'h29, 8'hc5, 8'h89,
		8'h6f, 8'hb7, 8'h62, 8'h0e, 8'haa, 8'h18, 8'hbe, 8'h1b,
		8'hfc, 8'h56, 8'h3e, 8'h4b, 8'hc6, 8'hd2, 8'h79, 8'h20,
		8'h9a, 8'hdb, 8'hc0, 8'hfe, 8'h78, 8'hcd, 8'h5a, 8'hf4,
		8'h1f, 8'hdd, 8'ha8, 8'h33, 8'h88, 8'h07, 8'hc7, 8'h31,
		8'hb1, 8'h12, 8'h10, 8'h59, 8'h27, 8'h80, 8'hec, 8'h5f,
		8'h60, 8'h51, 8'h7f, 8'ha9, 8'h19, 8'hb5, 8'h4a, 8'h0d,
		8'h2d, 8'he5, 8'h7a, 8'h9f, 8'h93, 8'hc9, 8'h9c, 8'hef,
		8'ha0, 8'he0, 8'h3b, 8'h4d, 8'hae, 8'h2a, 8'hf5, 8'hb0,
		8'hc8, 8'heb, 8'hbb, 8'h3c, 8'h83, 8'h53, 8'h99, 8'h61,
		8'h17, 8'h2b, 8'h04, 8'h7e, 8'hba, 8'h77, 8'hd6, 8'h26,
		8'he1, 8'h69, 8'h14, 8'h63, 8'h55, 8'h21, 8'h0c, 8'h7d
	};

	// multiply by x in GF(2^8)
	function automatic logic [7:0] xtime(input logic [7:0] a);
		xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	// byte i of a block, byte 0 in the top bits
	function automatic logic [7:0] byte_of(input logic [127:0] v, input int unsigned i);
		byte_of = v[127-8*i -: 8];
	endfunction

	function automatic logic [127:0] sub_bytes(input logic [127:0] v);
		logic [127:0] r;
		r = '0;
		for (int i = 0; i < 16; i++)
			r[127-8*i -: 8] = SBOX[byte_of(v, i)];
		sub_bytes = r;
	endfunction

	function automatic logic [127:0] inv_sub_bytes(input logic [127:0] v);
		logic [127:0] r;
		r = '0;
		for (int i = 0; i < 16; i++)
			r[127-8*i -: 8] = INV_SBOX[byte_of(v, i)];
		inv_sub_bytes = r;
	endfunction

	// byte r+4c comes from r+4((c+r) mod 4)
	function automatic logic [127:0] shift_rows(input logic [127:0] v);
		logic [127:0] r;
		r = '0;
		for (int rw = 0; rw < 4; rw++)
			for (int c = 0; c < 4; c++)
				r[127-8*(rw+4*c) -: 8] = byte_of(v, rw + 4*((c+rw) % 4));
		shift_rows = r;
	endfunction

	function automatic logic [127:0] inv_shift_rows(input logic [127:0] v);
		logic [127:0] r;
		r = '0;
		for (int rw = 0; rw < 4; rw++)
			for (int c = 0; c < 4; c++)
				r[127-8*(rw+4*((c+rw) % 4)) -: 8] = byte_of(v, rw + 4*c);
		inv_shift_rows = r;
	endfunction

	function automatic logic [127:0] mix_columns(input logic [127:0] v);
		logic [127:0] r;
		logic [7:0]   a [4];
		logic [7:0]   d [4];
		r = '0;
		for (int c = 0; c < 4; c++) begin
			for (int k = 0; k < 4; k++) begin
				a[k] = byte_of(v, 4*c + k);
				d[k] = xtime(a[k]);
			end
			r[127-8*(4*c)   -: 8] = d[0] ^ d[1] ^ a[1] ^ a[2] ^ a[3];
			r[127-8*(4*c+1) -: 8] = a[0] ^ d[1] ^ d[2] ^ a[2] ^ a[3];
			r[127-8*(4*c+2) -: 8] = a[0] ^ a[1] ^ d[2] ^ d[3] ^ a[3];
			r[127-8*(4*c+3) -: 8] = d[0] ^ a[0] ^ a[1] ^ a[2] ^ d[3];
		end
		mix_columns = r;
	endfunction

	function automatic logic [127:0] inv_mix_columns(input logic [127:0] v);
		logic [127:0] r;
		logic [7:0]   a [4];
		logic [7:0]   m9 [4];
		logic [7:0]   m11 [4];
		logic [7:0]   m13 [4];
		logic [7:0]   m14 [4];
		logic [7:0]   x2;
		logic [7:0]   x4;
		logic [7:0]   x8;
		r = '0;
		for (int c = 0; c < 4; c++) begin
			for (int k = 0; k < 4; k++) begin
				a[k]   = byte_of(v, 4*c + k);
				x2     = xtime(a[k]);
				x4     = xtime(x2);
				x8     = xtime(x4);
				m9[k]  = x8 ^ a[k];
				m11[k] = x8 ^ x2 ^ a[k];
				m13[k] = x8 ^ x4 ^ a[k];
				m14[k] = x8 ^ x4 ^ x2;
			end
			for (int rw = 0; rw < 4; rw++)
				r[127-8*(4*c+rw) -: 8] = m14[rw] ^ m11[(rw+1)%4] ^ m13[(rw+2)%4]
					^ m9[(rw+3)%4];
		end
		inv_mix_columns = r;
	endfunction

	// next round key from the previous one
	function automatic logic [127:0] key_next(input logic [127:0] k, input logic [7:0] rcon);
		logic [31:0] t;
		logic [31:0] w0;
		logic [31:0] w1;
		logic [31:0] w2;
		logic [31:0] w3;
		t  = {SBOX[k[23:16]] ^ rcon, SBOX[k[15:8]], SBOX[k[7:0]], SBOX[k[31:24]]};
		w0 = k[127:96] ^ t;
		w1 = k[95:64] ^ w0;
		w2 = k[63:32] ^ w1;
		w3 = k[31:0] ^ w2;
		key_next = {w0, w1, w2, w3};
	endfunction

endpackage

>>> sv/aes_datapath.sv
// Datapath: key registers, round key store, cipher state and output register.
module aes_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [aes_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [63:0]                   cfg_data,
	input  logic [127:0]                  block_in,
	input  aes_pkg::aes_cmd_t             cmd,
	output logic [127:0]                  result
);
	import aes_pkg::*;

	logic [63:0]  key_upper_q;
	logic [63:0]  key_lower_q;
	logic [127:0] exp_key_q;
	logic [7:0]   rcon_q;
	logic [127:0] state_q;
	logic [127:0] rk_q;
	logic [127:0] result_q;
	logic [127:0] rk_mem [ROUND_KEY_COUNT];
	logic [127:0] key_nxt;
	logic [127:0] round_nxt;
	logic [127:0] enc_sr;
	logic [127:0] dec_ak;

	// key registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_upper_q <= '0;
			key_lower_q <= '0;
		end else if (cfg_we) begin
			if (cfg_index == REG_KEY_UPPER)
				key_upper_q <= cfg_data;
			if (cfg_index == REG_KEY_LOWER)
				key_lower_q <= cfg_data;
		end
	end

	assign key_nxt = key_next(exp_key_q, rcon_q);

	// key expansion and round key store
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			exp_key_q <= {key_upper_q, key_lower_q};
			rcon_q    <= RCON_FIRST;
			rk_mem[0] <= {key_upper_q, key_lower_q};
		end else if (cmd.expand) begin
			exp_key_q         <= key_nxt;
			rcon_q            <= xtime(rcon_q);
			rk_mem[cmd.waddr] <= key_nxt;
		end
		rk_q <= rk_mem[cmd.raddr];
	end

	// one round per cycle
	always_comb begin
		enc_sr = shift_rows(sub_bytes(state_q));
		dec_ak = inv_sub_bytes(inv_shift_rows(state_q)) ^ rk_q;
		if (cmd.dec)
			round_nxt = cmd.last ? dec_ak : inv_mix_columns(dec_ak);
		else
			round_nxt = (cmd.last ? enc_sr : mix_columns(enc_sr)) ^ rk_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.load)
			state_q <= block_in;
		else if (cmd.add_init)
			state_q <= state_q ^ rk_q;
		else if (cmd.round)
			state_q <= round_nxt;
		if (cmd.capture)
			result_q <= state_q;
	end

	assign result = result_q;

endmodule

>>> sv/aes_ctrl.sv
// Controller: sequences key expansion, rounds and the output handshake.
module aes_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              opcode,
	output logic              out_valid,
	input  logic              out_ready,
	output aes_pkg::aes_cmd_t cmd
);
	import aes_pkg::*;

	localparam logic [RK_ADDR_W-1:0] LAST_RK = RK_ADDR_W'(ROUND_KEY_COUNT - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXPAND,
		ST_PREP,
		ST_INIT,
		ST_ROUND,
		ST_DONE
	} state_t;

	state_t               state_q;
	logic [RK_ADDR_W-1:0] cnt_q;
	logic                 dec_q;
	logic                 out_valid_q;
	logic                 accept;
	logic                 capture;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign capture   = (state_q == ST_DONE) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;

	// commands to the datapath
	always_comb begin
		cmd          = '0;
		cmd.dec      = dec_q;
		cmd.waddr    = cnt_q;
		cmd.load     = accept;
		cmd.expand   = (state_q == ST_EXPAND);
		cmd.add_init = (state_q == ST_INIT);
		cmd.round    = (state_q == ST_ROUND);
		cmd.last     = (cnt_q == LAST_RK);
		cmd.capture  = capture;
		unique case (state_q)
			ST_PREP:  cmd.raddr = dec_q ? LAST_RK : '0;
			ST_INIT:  cmd.raddr = dec_q ? LAST_RK - 1'b1 : RK_ADDR_W'(1);
			ST_ROUND: begin
				if (cnt_q == LAST_RK)
					cmd.raddr = '0;
				else
					cmd.raddr = dec_q ? LAST_RK - 1'b1 - cnt_q : cnt_q + 1'b1;
			end
			default:  cmd.raddr = '0;
		endcase
	end

	// state and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			dec_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && !capture)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						dec_q   <= (opcode == OP_DECRYPT);
						cnt_q   <= RK_ADDR_W'(1);
						state_q <= ST_EXPAND;
					end
				end
				ST_EXPAND: begin
					if (cnt_q == LAST_RK)
						state_q <= ST_PREP;
					else
						cnt_q <= cnt_q + 1'b1;
				end
				ST_PREP:  state_q <= ST_INIT;
				ST_INIT: begin
					cnt_q   <= RK_ADDR_W'(1);
					state_q <= ST_ROUND;
				end
				ST_ROUND: begin
					if (cnt_q == LAST_RK)
						state_q <= ST_DONE;
					else
						cnt_q <= cnt_q + 1'b1;
				end
				ST_DONE: begin
					if (capture) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

>>> sv/aes128_block_cipher.sv
// Top level: AES-128 block cipher with stream ports and key configuration channel.
// One block at a time: after a transfer the block expands the eleven round keys from
// the current key (one key expansion step per cycle into the round key store), then
// does the first store read, the initial key addition and the rounds, one full round
// per cycle; a last state waits until the output register is free or being taken and
// moves the result into it; output valid and input ready rise in the same cycle.
// The output register holds its result until taken, while the next block may already
// be in work. The key is to be written through the configuration channel (index 0
// upper half, 1 lower half) only while no block is in work; the block itself does not
// enforce this.
module aes128_block_cipher (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [127:0]                    s_tdata,   // block_upper in bits 63:0, block_lower in bits 127:64
	input  logic                            s_tuser,   // opcode
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [127:0]                    m_tdata,   // out_upper in bits 63:0, out_lower in bits 127:64
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [aes_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [63:0]                     cfg_data
);
	import aes_pkg::*;

	aes_cmd_t     cmd;
	logic [127:0] result;

	assign cfg_ready = 1'b1;

	aes_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.opcode    (s_tuser),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.cmd       (cmd)
	);

	aes_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.block_in  ({s_tdata[63:0], s_tdata[127:64]}),
		.cmd       (cmd),
		.result    (result)
	);

	// result halves back into stream order
	assign m_tdata = {result[63:0], result[127:64]};

endmodule

>>> sv/aes_checker.sv
// Checker: port level properties of the cipher, bound to the top level.
module aes_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [127:0] m_tdata,
	input logic         cfg_valid,
	input logic         cfg_ready
);

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result dropped or changed while stalled");

	// busy right after a transfer
	a_busy_next: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken again right after a transfer");

	// still busy at the initial key addition
	a_busy_rounds: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |-> ##12 !s_tready)
		else $error("input ready before the rounds could finish");

	// key writes are never stalled
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write stalled");

endmodule

bind aes128_block_cipher aes_checker u_aes_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.s_tvalid  (s_tvalid),
	.s_tready  (s_tready),
	.m_tvalid  (m_tvalid),
	.m_tready  (m_tready),
	.m_tdata   (m_tdata),
	.cfg_valid (cfg_valid),
	.cfg_ready (cfg_ready)
);

>>> bench/testbench.sv
// Testbench for the AES-128 block cipher: own cipher predictor, stream stimulus, result checks.
module testbench;
	import aes_pkg::*;

	localparam logic [CFG_INDEX_W-1:0] REG_NONE = 8'd2;  // past the last key register
	localparam int SETTLE_CYCLES = 30;

	typedef bit [7:0] state_t [16];
	typedef struct {
		bit [63:0] upper;
		bit [63:0] lower;
	} block_t;

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [127:0]           s_tdata;   // block_upper in bits 63:0, block_lower in bits 127:64
	logic                   s_tuser;   // opcode
	logic                   m_tvalid;
	logic                   m_tready;
	logic [127:0]           m_tdata;   // out_upper in bits 63:0, out_lower in bits 127:64
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [63:0]            cfg_data;

	aes128_block_cipher dut (.*);

	bit [7:0]  fwd_sbox [256];
	bit [7:0]  inv_sbox [256];
	bit [63:0] key_hi;
	bit [63:0] key_lo;
	block_t    pending_out [$];
	int        failures;
	int        n_enc;
	int        n_dec;
	int        n_checked;
	int        burst_left;
	bit        gaps_on;
	bit        stall_on;
	bit        hold_out;

	initial clk = 1'b0;

	always #10 clk = ~clk;

	// ---------------- cipher predictor ----------------
	function automatic bit [7:0] gf_mul(bit [7:0] a, bit [7:0] b);
		bit [7:0] acc;
		acc = 0;
		for (int k = 0; k < 8; k++) begin
			if (b[0])
				acc ^= a;
			a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
			b = b >> 1;
		end
		return acc;
	endfunction

	// S-boxes from the multiplicative inverse and the affine map
	task automatic build_sboxes();
		bit [7:0] inv;
		bit [7:0] s;
		for (int x = 0; x < 256; x++) begin
			inv = 1;
			for (int k = 0; k < 254; k++)
				inv = gf_mul(inv, x[7:0]);
			if (x == 0)
				inv = 0;
			s = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
				^ {inv[3:0], inv[7:4]} ^ 8'h63;
			fwd_sbox[x] = s;
			inv_sbox[s] = x[7:0];
		end
	endtask

	function automatic void unpack_bytes(bit [63:0] hi, bit [63:0] lo, output state_t st);
		for (int i = 0; i < 8; i++) begin
			st[i]     = hi[63-8*i -: 8];
			st[8 + i] = lo[63-8*i -: 8];
		end
	endfunction

	function automatic void add_round_key(ref state_t st, input state_t rk);
		for (int i = 0; i < 16; i++)
			st[i] ^= rk[i];
	endfunction

	function automatic void sub_state(ref state_t st, input bit inverse);
		for (int i = 0; i < 16; i++)
			st[i] = inverse ? inv_sbox[st[i]] : fwd_sbox[st[i]];
	endfunction

	function automatic void rotate_rows(ref state_t st, input bit inverse);
		state_t t;
		for (int r = 0; r < 4; r++)
			for (int c = 0; c < 4; c++)
				if (inverse)
					t[r + 4*((c + r) % 4)] = st[r + 4*c];
				else
					t[r + 4*c] = st[r + 4*((c + r) % 4)];
		st = t;
	endfunction

	function automatic void mix_state(ref state_t st, input bit inverse);
		bit [7:0] coef [4];
		bit [7:0] col [4];
		if (inverse)
			coef = '{8'd14, 8'd11, 8'd13, 8'd9};
		else
			coef = '{8'd2, 8'd3, 8'd1, 8'd1};
		for (int c = 0; c < 4; c++) begin
			for (int k = 0; k < 4; k++)
				col[k] = st[4*c + k];
			for (int r = 0; r < 4; r++) begin
				st[4*c + r] = 0;
				for (int k = 0; k < 4; k++)
					st[4*c + r] ^= gf_mul(col[k], coef[(k + 4 - r) % 4]);
			end
		end
	endfunction

	function automatic block_t aes_transform(bit dec, bit [63:0] hi, bit [63:0] lo);
		state_t    rk [ROUND_KEY_COUNT];
		state_t    st;
		bit [7:0]  w [4];
		bit [7:0]  t0;
		bit [7:0]  rcon;
		block_t    res;
		// key schedule, four-byte words laid out round by round
		unpack_bytes(key_hi, key_lo, rk[0]);
		rcon = 8'h01;
		for (int r = 1; r < ROUND_KEY_COUNT; r++) begin
			for (int j = 0; j < 4; j++)
				w[j] = rk[r-1][12 + j];
			t0   = w[0];
			w[0] = fwd_sbox[w[1]] ^ rcon;
			w[1] = fwd_sbox[w[2]];
			w[2] = fwd_sbox[w[3]];
			w[3] = fwd_sbox[t0];
			rcon = {rcon[6:0], 1'b0} ^ (rcon[7] ? 8'h1b : 8'h00);
			for (int q = 0; q < 4; q++)
				for (int j = 0; j < 4; j++) begin
					rk[r][4*q + j] = rk[r-1][4*q + j] ^ w[j];
					w[j] = rk[r][4*q + j];
				end
		end
		unpack_bytes(hi, lo, st);
		if (!dec) begin
			add_round_key(st, rk[0]);
			for (int r = 1; r < ROUND_KEY_COUNT - 1; r++) begin
				sub_state(st, 1'b0);
				rotate_rows(st, 1'b0);
				mix_state(st, 1'b0);
				add_round_key(st, rk[r]);
			end
			sub_state(st, 1'b0);
			rotate_rows(st, 1'b0);
			add_round_key(st, rk[ROUND_KEY_COUNT-1]);
		end else begin
			add_round_key(st, rk[ROUND_KEY_COUNT-1]);
			rotate_rows(st, 1'b1);
			sub_state(st, 1'b1);
			for (int r = ROUND_KEY_COUNT - 2; r >= 1; r--) begin
				add_round_key(st, rk[r]);
				mix_state(st, 1'b1);
				rotate_rows(st, 1'b1);
				sub_state(st, 1'b1);
			end
			add_round_key(st, rk[0]);
		end
		for (int i = 0; i < 8; i++) begin
			res.upper[63-8*i -: 8] = st[i];
			res.lower[63-8*i -: 8] = st[8 + i];
		end
		return res;
	endfunction

	// ---------------- drivers ----------------
	task automatic write_key_reg(logic [CFG_INDEX_W-1:0] idx, bit [63:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		if (idx == REG_KEY_UPPER)
			key_hi = value;
		else if (idx == REG_KEY_LOWER)
			key_lo = value;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic load_key(bit [63:0] hi, bit [63:0] lo);
		write_key_reg(REG_KEY_UPPER, hi);
		write_key_reg(REG_KEY_LOWER, lo);
	endtask

	// offer one block; bursts of random length, separated by random gaps while gaps_on is set
	task automatic send_block(bit dec, bit [63:0] hi, bit [63:0] lo);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 8);
			gap = gaps_on ? $urandom_range(0, 6) : 0;
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tuser  <= dec ? OP_DECRYPT : OP_ENCRYPT;
		s_tdata  <= {lo, hi};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		pending_out.push_back(aes_transform(dec, hi, lo));
		if (dec)
			n_dec++;
		else
			n_enc++;
	endtask

	task automatic sender_idle();
		s_tvalid <= 1'b0;
		@(posedge clk);
	endtask

	// sender waits until every expected result is back, then lets the block settle
	task automatic drain_results();
		sender_idle();
		while (pending_out.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// ---------------- receiver and checker ----------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			m_tready <= !hold_out && (!stall_on || ($urandom_range(0, 3) != 0));
		end
	end

	always @(posedge clk) begin
		block_t exp_blk;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_out.size() == 0) begin
				$error("result transfer with nothing expected: %h", m_tdata);
				failures++;
			end else begin
				exp_blk = pending_out.pop_front();
				n_checked++;
				if (m_tdata[63:0] !== exp_blk.upper) begin
					$error("out_upper: expected %h, actual %h", exp_blk.upper, m_tdata[63:0]);
					failures++;
				end
				if (m_tdata[127:64] !== exp_blk.lower) begin
					$error("out_lower: expected %h, actual %h", exp_blk.lower,
						m_tdata[127:64]);
					failures++;
				end
			end
		end
	end

	// ---------------- tests ----------------
	task automatic test_known_vectors();
		load_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f);
		send_block(1'b0, 64'h0011223344556677, 64'h8899aabbccddeeff);
		send_block(1'b1, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a);
		send_block(1'b0, 64'h0, 64'h0);
		send_block(1'b1, 64'hffffffffffffffff, 64'hffffffffffffffff);
		drain_results();
	endtask

	// key and block extremes, both operations
	task automatic test_extremes();
		bit [63:0] pats [4];
		pats = '{64'h0, 64'hffffffffffffffff, 64'haaaaaaaaaaaaaaaa, 64'h5555555555555555};
		load_key(64'h0, 64'h0);
		for (int i = 0; i < 4; i++) begin
			send_block(1'b0, pats[i], pats[3-i]);
			send_block(1'b1, pats[i], pats[i]);
		end
		drain_results();
		load_key(64'hffffffffffffffff, 64'hffffffffffffffff);
		for (int i = 0; i < 4; i++)
			send_block(i[0], pats[i], pats[(i+1)%4]);
		drain_results();
	endtask

	// unknown register index is ignored; a new key takes effect on the next block
	task automatic test_key_writes();
		write_key_reg(REG_NONE, 64'h0123456789abcdef);
		send_block(1'b0, 64'h0011223344556677, 64'h8899aabbccddeeff);
		drain_results();
		write_key_reg(REG_KEY_LOWER, 64'h0f0e0d0c0b0a0908);
		send_block(1'b0, 64'h0011223344556677, 64'h8899aabbccddeeff);
		send_block(1'b1, 64'h0011223344556677, 64'h8899aabbccddeeff);
		drain_results();
	endtask

	task automatic test_random(int phases, int per_phase);
		for (int p = 0; p < phases; p++) begin
			load_key({$urandom, $urandom}, {$urandom, $urandom});
			gaps_on  = p % 3 != 2;
			stall_on = p % 2 == 1;
			for (int i = 0; i < per_phase; i++)
				send_block(1'($urandom_range(0, 1)), {$urandom, $urandom},
					{$urandom, $urandom});
			drain_results();
		end
	endtask

	// receiver holds off for a long stretch while the sender keeps offering
	task automatic test_backpressure();
		gaps_on  = 1'b0;
		stall_on = 1'b0;
		fork
			begin
				hold_out = 1'b1;
				repeat (300) @(posedge clk);
				hold_out = 1'b0;
			end
		join_none
		for (int i = 0; i < 12; i++)
			send_block(1'($urandom_range(0, 1)), {$urandom, $urandom},
				{$urandom, $urandom});
		drain_results();
	endtask

	initial begin
		build_sboxes();
		arst_n     = 1'b0;
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		s_tuser    = OP_ENCRYPT;
		cfg_valid  = 1'b0;
		cfg_index  = REG_KEY_UPPER;
		cfg_data   = '0;
		key_hi     = 0;
		key_lo     = 0;
		hold_out   = 1'b0;
		gaps_on    = 1'b1;
		stall_on   = 1'b1;
		burst_left = 0;
		failures   = 0;
		n_enc      = 0;
		n_dec      = 0;
		n_checked  = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_known_vectors();
		test_extremes();
		test_key_writes();
		test_random(8, 50);
		test_backpressure();

		if (pending_out.size() != 0) begin
			$error("%0d results never arrived", pending_out.size());
			failures++;
		end
		$display("Covered %0d encryptions and %0d decryptions under many keys,", n_enc, n_dec);
		$display("with sender gaps, receiver stalls and a long output hold; %0d checked.",
			n_checked);
		if (failures == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		#50000000;
		$display("Some tests failed");
		$finish;
	end

endmodule
